/* src/bme_pkg.sv */
// Package for the bit matrix engine: word types, function and register codes,
// controller/datapath handshake structs and the popcount helper.
// Depends on nothing; the design files use it by scoped names, the testbench imports it.
package bme_pkg;

   // Default sizes, handed to the top level parameters.
   localparam int DEF_MAX_ROWS    = 64;
   localparam int DEF_MAX_COLUMNS = 256;
   localparam int DEF_WORD_BITS   = 64;

   // Field widths fixed by the command and result word layout.
   localparam int ROW_IDX_W  = 6;
   localparam int COL_IDX_W  = 8;
   localparam int FUNC_W     = 4;
   localparam int COUNT_W    = 15;
   localparam int ROWS_REG_W = 7;
   localparam int COLS_REG_W = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   // Register reset values and the count ceiling.
   localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 7'd64;
   localparam logic [COLS_REG_W-1:0] COLS_RESET = 9'd256;
   localparam logic [COUNT_W-1:0]    COUNT_MAX  = 15'h7FFF;

   // Command function codes.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_SET        = 4'd0,
      FUNC_CLEAR      = 4'd1,
      FUNC_FLIP       = 4'd2,
      FUNC_READ       = 4'd3,
      FUNC_CLEAR_ALL  = 4'd4,
      FUNC_FILL_ALL   = 4'd5,
      FUNC_NEGATE_ALL = 4'd6,
      FUNC_COUNT      = 4'd7,
      FUNC_HAMMING    = 4'd8,
      FUNC_SUBSET     = 4'd9
   } func_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS_IN_USE    = 2'd0,
      CSR_COLUMNS_IN_USE = 2'd1
   } csr_index_type;

   // Command word.
   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic                 bank;
      logic [ROW_IDX_W-1:0] row_index;
      logic [COL_IDX_W-1:0] column_index;
   } req_word_type;

   // Result word.
   typedef struct packed {
      logic               bit_value;
      logic [COUNT_W-1:0] count;
      logic               subset_flag;
   } rsp_word_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic clear_step;
      logic walk_step;
      logic bit_commit;
      logic finish;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic walk_empty;
      logic walk_last;
      logic pipe_idle;
   } dp_status_type;

   // Ones count of one byte.
   function automatic logic [3:0] pop8(input logic [7:0] v);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + {3'b000, v[i]};
      end
      return n;
   endfunction

endpackage

/* src/bme_ctrl.sv */
// Controller state machine of the bit matrix engine.
// Depends on bme_pkg for the command and status structs and function codes.
module bme_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [bme_pkg::FUNC_W-1:0]        req_func,
   input  bme_pkg::dp_status_type            status,
   output bme_pkg::ctrl_cmd_type             cmd,
   output logic                              busy
);

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_BIT    = 7'b0000100,
      S_BIT_WB = 7'b0001000,
      S_WALK   = 7'b0010000,
      S_DRAIN  = 7'b0100000,
      S_FINISH = 7'b1000000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (req_func <= bme_pkg::FUNC_READ) begin
                  state_in = S_BIT;
               end else if (req_func <= bme_pkg::FUNC_SUBSET && !status.walk_empty) begin
                  state_in = S_WALK;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_BIT: begin
            state_in = S_BIT_WB;
         end
         S_BIT_WB: begin
            cmd.bit_commit = 1'b1;
            cmd.finish     = 1'b1;
            state_in       = S_IDLE;
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (status.pipe_idle) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

`ifndef NO_ASSERTIONS
   // An accepted command raises busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not raise busy");

   // The datapath pipeline has drained whenever a walk result is produced.
   a_drain_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN && cmd.finish) |-> status.pipe_idle)
      else $error("walk finished with words still in flight");

   // The state register always holds exactly one active state bit.
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state is not one-hot");
`endif

endmodule

/* src/bme_datapath.sv */
// Datapath of the bit matrix engine: configuration registers, the two bank
// memories, the walk counters, the popcount pipeline and the result register.
// Depends on bme_pkg for word types, codes and the popcount helper.
module bme_datapath #(
   parameter int MAX_ROWS    = bme_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLUMNS = bme_pkg::DEF_MAX_COLUMNS,
   parameter int WORD_BITS   = bme_pkg::DEF_WORD_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bme_pkg::ctrl_cmd_type               cmd,
   output bme_pkg::dp_status_type              status,
   input  bme_pkg::req_word_type               req_word,
   input  logic                                csr_valid,
   input  logic [bme_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bme_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                rsp_valid,
   output bme_pkg::rsp_word_type               rsp_word
);

   localparam int WPR     = (MAX_COLUMNS + WORD_BITS - 1) / WORD_BITS;
   localparam int DEPTH   = MAX_ROWS * WPR;
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WIW     = (WPR > 1) ? $clog2(WPR) : 1;
   localparam int BPW     = $clog2(WORD_BITS);
   localparam int NCH     = (WORD_BITS + 7) / 8;
   localparam int PCW     = $clog2(WORD_BITS + 1);
   localparam int ROW_CAP = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
   localparam int COL_CAP = (MAX_COLUMNS > 511) ? 511 : MAX_COLUMNS;
   localparam int NCOLS   = 2 ** bme_pkg::COL_IDX_W;
   localparam int RW      = bme_pkg::ROWS_REG_W;
   localparam int CW      = bme_pkg::COLS_REG_W;
   localparam int NW      = bme_pkg::COUNT_W;

   localparam logic [WORD_BITS-1:0] FULL_WORD = {WORD_BITS{1'b1}};
   localparam logic [CW-1:0]        WB_C      = CW'(WORD_BITS);
   localparam logic [AW-1:0]        LAST_ADDR = AW'(DEPTH - 1);

   // Configuration registers.
   logic [RW-1:0] rows_ff;
   logic [CW-1:0] cols_ff;
   logic [RW-1:0] eff_rows;
   logic [CW-1:0] eff_cols;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= bme_pkg::ROWS_RESET;
         cols_ff <= bme_pkg::COLS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            bme_pkg::CSR_ROWS_IN_USE:    rows_ff <= csr_wdata[RW-1:0];
            bme_pkg::CSR_COLUMNS_IN_USE: cols_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Values above the maximum act as the maximum.
   assign eff_rows = (rows_ff > RW'(ROW_CAP)) ? RW'(ROW_CAP) : rows_ff;
   assign eff_cols = (cols_ff > CW'(COL_CAP)) ? CW'(COL_CAP) : cols_ff;

   // Latched command word.
   bme_pkg::req_word_type item_ff;
   logic is_whole_write;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_word;
      end
   end

   assign is_whole_write = (item_ff.func == bme_pkg::FUNC_CLEAR_ALL) ||
                           (item_ff.func == bme_pkg::FUNC_FILL_ALL)  ||
                           (item_ff.func == bme_pkg::FUNC_NEGATE_ALL);

   // Column to word and bit position tables, fixed at elaboration.
   logic [WIW-1:0] q_tab   [NCOLS];
   logic [BPW-1:0] pos_tab [NCOLS];

   for (genvar gi = 0; gi < NCOLS; gi++) begin : g_col_tab
      assign q_tab[gi]   = WIW'(gi / WORD_BITS);
      assign pos_tab[gi] = BPW'(WORD_BITS - 1 - gi % WORD_BITS);
   end

   // Single-bit addressing.
   logic                 bit_in_range;
   logic [AW-1:0]        bit_addr;
   logic [WORD_BITS-1:0] bit_mask;

   assign bit_in_range = ({1'b0, item_ff.row_index} < eff_rows) &&
                         ({1'b0, item_ff.column_index} < eff_cols);
   assign bit_addr = bit_in_range ?
      AW'(32'(item_ff.row_index) * 32'(WPR) + 32'(q_tab[item_ff.column_index])) : '0;
   assign bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << pos_tab[item_ff.column_index];

   // Walk counters: row, word within the row and columns left in the row.
   logic [RW-1:0]        row_ff, row_in;
   logic [WIW-1:0]       word_ff, word_in;
   logic [CW-1:0]        rem_ff, rem_in;
   logic                 row_end;
   logic [AW-1:0]        walk_addr;
   logic [WORD_BITS-1:0] walk_mask;

   assign row_end   = (rem_ff <= WB_C);
   assign walk_addr = AW'(32'(row_ff) * 32'(WPR) + 32'(word_ff));
   assign walk_mask = (rem_ff >= WB_C) ? FULL_WORD : ~(FULL_WORD >> rem_ff);

   always_comb begin
      row_in  = row_ff;
      word_in = word_ff;
      rem_in  = rem_ff;
      if (cmd.load) begin
         row_in  = '0;
         word_in = '0;
         rem_in  = eff_cols;
      end else if (cmd.walk_step) begin
         if (row_end) begin
            row_in  = row_ff + RW'(1);
            word_in = '0;
            rem_in  = eff_cols;
         end else begin
            word_in = word_ff + WIW'(1);
            rem_in  = rem_ff - WB_C;
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff  <= row_in;
      word_ff <= word_in;
      rem_ff  <= rem_in;
   end

   // Clearing pass address.
   logic [AW-1:0] clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   // Stage 1: read data of the issued word arrives with its mask.
   logic                 p1_valid_ff;
   logic [AW-1:0]        p1_addr_ff;
   logic [WORD_BITS-1:0] p1_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= cmd.walk_step;
      end
      p1_addr_ff <= walk_addr;
      p1_mask_ff <= walk_mask;
   end

   // Bank memories, one read and one write port each.
   logic [WORD_BITS-1:0] bank_a_mem [DEPTH];
   logic [WORD_BITS-1:0] bank_b_mem [DEPTH];
   logic [WORD_BITS-1:0] rd_a_ff, rd_b_ff, rd_sel;
   logic [AW-1:0]        raddr, waddr;
   logic [WORD_BITS-1:0] wdata, walk_wdata, bit_wdata;
   logic                 walk_we, bit_we, we_a, we_b;

   assign raddr  = cmd.walk_step ? walk_addr : bit_addr;
   assign rd_sel = item_ff.bank ? rd_b_ff : rd_a_ff;

   // New word for a whole-matrix write.
   always_comb begin
      case (item_ff.func)
         bme_pkg::FUNC_FILL_ALL:   walk_wdata = FULL_WORD;
         bme_pkg::FUNC_NEGATE_ALL: walk_wdata = ~rd_sel;
         default:                  walk_wdata = '0;
      endcase
   end

   // New word for a single-bit write.
   always_comb begin
      case (item_ff.func)
         bme_pkg::FUNC_SET:   bit_wdata = rd_sel | bit_mask;
         bme_pkg::FUNC_CLEAR: bit_wdata = rd_sel & ~bit_mask;
         default:             bit_wdata = rd_sel ^ bit_mask;
      endcase
   end

   assign walk_we = p1_valid_ff && is_whole_write;
   assign bit_we  = cmd.bit_commit && bit_in_range && (item_ff.func <= bme_pkg::FUNC_FLIP);
   assign we_a    = cmd.clear_step || ((walk_we || bit_we) && !item_ff.bank);
   assign we_b    = cmd.clear_step || ((walk_we || bit_we) && item_ff.bank);
   assign waddr   = cmd.clear_step ? clr_ff : (p1_valid_ff ? p1_addr_ff : bit_addr);
   assign wdata   = cmd.clear_step ? '0 : (p1_valid_ff ? walk_wdata : bit_wdata);

   always_ff @(posedge clock) begin
      if (we_a) begin
         bank_a_mem[waddr] <= wdata;
      end
      rd_a_ff <= bank_a_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (we_b) begin
         bank_b_mem[waddr] <= wdata;
      end
      rd_b_ff <= bank_b_mem[raddr];
   end

   // Stage 2: byte ones counts of the masked word and the subset check.
   logic                 p2_valid_ff;
   logic [3:0]           ch_ff [NCH];
   logic [3:0]           ch_in [NCH];
   logic                 viol2_ff;
   logic [WORD_BITS-1:0] cnt_word;
   logic [NCH*8-1:0]     cnt_pad;

   always_comb begin
      if (item_ff.func == bme_pkg::FUNC_HAMMING) begin
         cnt_word = (rd_a_ff ^ rd_b_ff) & p1_mask_ff;
      end else begin
         cnt_word = rd_sel & p1_mask_ff;
      end
      cnt_pad = (NCH*8)'(cnt_word);
      for (int i = 0; i < NCH; i++) begin
         ch_in[i] = bme_pkg::pop8(cnt_pad[i*8 +: 8]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= p1_valid_ff;
      end
      ch_ff    <= ch_in;
      viol2_ff <= |(rd_a_ff & ~rd_b_ff & p1_mask_ff);
   end

   // Stage 3: ones count of the whole word.
   logic           p3_valid_ff;
   logic [PCW-1:0] pc3_ff, pc3_in;
   logic           viol3_ff;

   always_comb begin
      pc3_in = '0;
      for (int i = 0; i < NCH; i++) begin
         pc3_in = pc3_in + PCW'(ch_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else begin
         p3_valid_ff <= p2_valid_ff;
      end
      pc3_ff   <= pc3_in;
      viol3_ff <= viol2_ff;
   end

   // Saturating count and subset accumulators.
   logic [NW-1:0] count_ff, count_in;
   logic [NW:0]   count_sum;
   logic          subset_ff, subset_in;

   assign count_sum = {1'b0, count_ff} + (NW+1)'(pc3_ff);

   always_comb begin
      count_in  = count_ff;
      subset_in = subset_ff;
      if (cmd.load) begin
         count_in  = '0;
         subset_in = 1'b1;
      end else if (p3_valid_ff) begin
         count_in  = (count_sum > (NW+1)'(bme_pkg::COUNT_MAX)) ?
                     bme_pkg::COUNT_MAX : count_sum[NW-1:0];
         subset_in = subset_ff && !viol3_ff;
      end
   end

   always_ff @(posedge clock) begin
      count_ff  <= count_in;
      subset_ff <= subset_in;
   end

   // Result register; shown for one cycle after the finish command.
   logic                  rsp_valid_ff;
   bme_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   always_comb begin
      rsp_word_in.bit_value   = (item_ff.func == bme_pkg::FUNC_READ) && bit_in_range &&
                                (|(rd_sel & bit_mask));
      rsp_word_in.count       = ((item_ff.func == bme_pkg::FUNC_COUNT) ||
                                 (item_ff.func == bme_pkg::FUNC_HAMMING)) ? count_ff : '0;
      rsp_word_in.subset_flag = (item_ff.func == bme_pkg::FUNC_SUBSET) && subset_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
      if (cmd.finish) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Status back to the controller.
   assign status.clear_last = (clr_ff == LAST_ADDR);
   assign status.walk_empty = (eff_rows == '0) || (eff_cols == '0);
   assign status.walk_last  = row_end && (row_ff == eff_rows - RW'(1));
   assign status.pipe_idle  = !p1_valid_ff && !p2_valid_ff && !p3_valid_ff;

`ifndef NO_ASSERTIONS
   // A result word is a single-cycle strobe.
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   // A walk write and a single-bit write never compete for the write port.
   a_wport_free: assert property (@(posedge clock) disable iff (reset)
      !(p1_valid_ff && cmd.bit_commit))
      else $error("walk write collided with a single-bit write");

   // The running count only grows while words retire.
   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      p3_valid_ff |=> (count_ff >= $past(count_ff)))
      else $error("running count decreased");
`endif

endmodule

/* src/bit_matrix_engine_unit.sv */
// Top level of the bit matrix engine: controller and datapath.
// Depends on bme_pkg, bme_ctrl and bme_datapath.
//
//   Channel   Ports                              Moves one word when
//   command   start, busy, req_word              start high and busy low
//   result    rsp_valid, rsp_word                rsp_valid high (one cycle)
//   config    csr_valid, csr_ready, csr_index,   csr_valid and csr_ready high
//             csr_wdata
//
// Single-bit commands read the cycle after accept, write back the next and strobe the
// result the cycle after that; a new word is taken no earlier than that strobe.
// Walking commands (4 to 9) step through the words in use of every active row, one word
// per cycle, then wait for the pipeline to drain; unused codes and empty walks skip the walk.
// After reset a clearing pass writes every memory word (MAX_ROWS x words per row,
// 256 words by default) with busy high. The result receiver takes every strobe.
module bit_matrix_engine_unit #(
   parameter int MAX_ROWS    = bme_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLUMNS = bme_pkg::DEF_MAX_COLUMNS,
   parameter int WORD_BITS   = bme_pkg::DEF_WORD_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  bme_pkg::req_word_type          req_word,
   output logic                           rsp_valid,
   output bme_pkg::rsp_word_type          rsp_word,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bme_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bme_pkg::CSR_DATA_W-1:0] csr_wdata
);

   bme_pkg::ctrl_cmd_type  cmd;
   bme_pkg::dp_status_type status;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   bme_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_word.func),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   bme_datapath #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLUMNS (MAX_COLUMNS),
      .WORD_BITS   (WORD_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_word  (req_word),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

/* tb/bit_matrix_engine_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for bit_matrix_engine_unit: directed table, then random phases.
// Depends on bme_pkg and the bit_matrix_engine_unit RTL; reads and writes no files.
module bit_matrix_engine_unit_tb;
   import bme_pkg::*;

   localparam int MAXR = DEF_MAX_ROWS;
   localparam int MAXC = DEF_MAX_COLUMNS;
   localparam int WORDB = DEF_WORD_BITS;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int DIRECTED_COUNT = 25;
   localparam int PHASES = 10;
   localparam int FIXED_PHASES = 8;
   localparam int PHASE_ITEMS = 103;
   localparam int FINAL_QUIET_CYCLES = 300;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_FIRST = FUNC_SUBSET + 4'd1;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_LAST = '1;

   // One row of the directed table; typed rows carry their expected word.
   typedef struct packed {
      req_word_type word;
      logic         typed;
      rsp_word_type result;
   } step_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_word_type          req_word = '0;
   logic                  rsp_valid;
   rsp_word_type          rsp_word;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_ROWS_IN_USE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow copy of both matrices and the registers; column c is bit c of a row.
   bit [MAXC-1:0]         bit_plane [2][MAXR];
   logic [ROWS_REG_W-1:0] rows_reg = ROWS_RESET;
   logic [COLS_REG_W-1:0] cols_reg = COLS_RESET;

   rsp_word_type pending_results [$];
   int unsigned  mismatch_count = 0;
   int unsigned  cycle_count = 0;

   bit_matrix_engine_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Run watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bit_matrix_engine_unit test failed");
         $finish;
      end
   end

   function automatic step_type dir_step(logic [FUNC_W-1:0] f, logic bank, int row, int col,
                                         logic typed, logic bv, int cnt, logic sf);
      step_type s;
      s.word.func         = f;
      s.word.bank         = bank;
      s.word.row_index    = ROW_IDX_W'(row);
      s.word.column_index = COL_IDX_W'(col);
      s.typed             = typed;
      s.result.bit_value  = bv;
      s.result.count      = COUNT_W'(cnt);
      s.result.subset_flag = sf;
      return s;
   endfunction

   // Directed commands under the reset sizes (64 rows, 256 columns).
   // The fifth argument marks rows whose expected word is typed in here.
   step_type directed_steps [DIRECTED_COUNT] = '{
      dir_step(FUNC_READ,         1'b0,  0,   0, 1'b1, 1'b0,     0, 1'b0),
      dir_step(FUNC_COUNT,        1'b0,  0,   0, 1'b1, 1'b0,     0, 1'b0),
      dir_step(FUNC_HAMMING,      1'b0,  0,   0, 1'b1, 1'b0,     0, 1'b0),
      dir_step(FUNC_SUBSET,       1'b0,  0,   0, 1'b1, 1'b0,     0, 1'b1),
      dir_step(FUNC_SET,          1'b0,  0,   0, 1'b1, 1'b0,     0, 1'b0),
      dir_step(FUNC_SET,          1'b0, 63, 255, 1'b1, 1'b0,     0, 1'b0),
      dir_step(FUNC_READ,         1'b0, 63, 255, 1'b1, 1'b1,     0, 1'b0),
      dir_step(FUNC_READ,         1'b0,  0,   0, 1'b1, 1'b1,     0, 1'b0),
      dir_step(FUNC_FLIP,         1'b1, 63, 255, 1'b0, 1'b0,     0, 1'b0),
      dir_step(FUNC_COUNT,        1'b0,  0,   0, 1'b0, 1'b0,     0, 1'b0),
      dir_step(FUNC_SUBSET,       1'b1,  0,   0, 1'b0, 1'b0,     0, 1'b0),
      dir_step(FUNC_CLEAR,        1'b0,  0,   0, 1'b0, 1'b0,     0, 1'b0),
      dir_step(FUNC_FILL_ALL,     1'b1,  0,   0, 1'b1, 1'b0,     0, 1'b0),
      dir_step(FUNC_COUNT,        1'b1,  0,   0, 1'b1, 1'b0, 16384, 1'b0),
      dir_step(FUNC_SUBSET,       1'b0,  0,   0, 1'b0, 1'b0,     0, 1'b0),
      dir_step(FUNC_NEGATE_ALL,   1'b0,  0,   0, 1'b0, 1'b0,     0, 1'b0),
      dir_step(FUNC_HAMMING,      1'b1,  0,   0, 1'b0, 1'b0,     0, 1'b0),
      dir_step(FUNC_COUNT,        1'b0,  0,   0, 1'b0, 1'b0,     0, 1'b0),
      dir_step(FUNC_NEGATE_ALL,   1'b1,  0,   0, 1'b0, 1'b0,     0, 1'b0),
      dir_step(FUNC_COUNT,        1'b1,  0,   0, 1'b1, 1'b0,     0, 1'b0),
      dir_step(FUNC_CLEAR_ALL,    1'b0,  0,   0, 1'b0, 1'b0,     0, 1'b0),
      dir_step(FUNC_COUNT,        1'b0,  0,   0, 1'b1, 1'b0,     0, 1'b0),
      dir_step(FUNC_UNUSED_FIRST, 1'b1, 63, 255, 1'b1, 1'b0,     0, 1'b0),
      dir_step(FUNC_UNUSED_LAST,  1'b0,  0,   0, 1'b1, 1'b0,     0, 1'b0),
      dir_step(FUNC_READ,         1'b1,  0, 255, 1'b0, 1'b0,     0, 1'b0)
   };

   // Register values above the maximum act as the maximum.
   function automatic int unsigned active_rows();
      return (rows_reg > MAXR) ? MAXR : int'(rows_reg);
   endfunction

   function automatic int unsigned active_columns();
      return (cols_reg > MAXC) ? MAXC : int'(cols_reg);
   endfunction

   // Applies one command to the shadow matrices and returns its result word.
   function automatic rsp_word_type apply_matrix_command(req_word_type cmd);
      rsp_word_type  res;
      int unsigned   nrows;
      int unsigned   ncols;
      int unsigned   span;
      int unsigned   total;
      bit [MAXC-1:0] valid_cols;
      bit [MAXC-1:0] touched_cols;
      res   = '0;
      total = 0;
      nrows = active_rows();
      ncols = active_columns();
      // Whole-matrix writes reach every column of each word that holds a column in use.
      span  = ((ncols + WORDB - 1) / WORDB) * WORDB;
      for (int c = 0; c < MAXC; c++) begin
         valid_cols[c]   = (c < ncols);
         touched_cols[c] = (c < span);
      end
      if (cmd.func <= FUNC_READ) begin
         // Bits outside the rows or columns in use are left alone and read as zero.
         if (cmd.row_index < nrows && cmd.column_index < ncols) begin
            case (cmd.func)
               FUNC_SET:   bit_plane[cmd.bank][cmd.row_index][cmd.column_index] = 1'b1;
               FUNC_CLEAR: bit_plane[cmd.bank][cmd.row_index][cmd.column_index] = 1'b0;
               FUNC_FLIP:  bit_plane[cmd.bank][cmd.row_index][cmd.column_index] ^= 1'b1;
               default:    res.bit_value = bit_plane[cmd.bank][cmd.row_index][cmd.column_index];
            endcase
         end
      end else if (cmd.func <= FUNC_NEGATE_ALL) begin
         for (int r = 0; r < nrows; r++) begin
            case (cmd.func)
               FUNC_CLEAR_ALL: bit_plane[cmd.bank][r] &= ~touched_cols;
               FUNC_FILL_ALL:  bit_plane[cmd.bank][r] |= touched_cols;
               default:        bit_plane[cmd.bank][r] ^= touched_cols;
            endcase
         end
      end else if (cmd.func <= FUNC_SUBSET) begin
         // Queries see only valid columns; padding never counts.
         res.subset_flag = (cmd.func == FUNC_SUBSET);
         for (int r = 0; r < nrows; r++) begin
            if (cmd.func == FUNC_COUNT)
               total += $countones(bit_plane[cmd.bank][r] & valid_cols);
            else if (cmd.func == FUNC_HAMMING)
               total += $countones((bit_plane[0][r] ^ bit_plane[1][r]) & valid_cols);
            else if ((bit_plane[0][r] & ~bit_plane[1][r] & valid_cols) != '0)
               res.subset_flag = 1'b0;
         end
         res.count = (total > COUNT_MAX) ? COUNT_MAX : total[COUNT_W-1:0];
      end
      return res;
   endfunction

   // Random command: mostly single-bit work, some whole-matrix work and queries,
   // a few unused codes. Positions often crowd a small corner so reads hit set bits.
   function automatic req_word_type random_command();
      req_word_type cmd;
      int unsigned  kind;
      int unsigned  where;
      int unsigned  nrows;
      int unsigned  ncols;
      nrows = active_rows();
      ncols = active_columns();
      kind  = $urandom_range(0, 99);
      where = $urandom_range(0, 9);
      if (kind < 62)
         cmd.func = FUNC_W'($urandom_range(FUNC_SET, FUNC_READ));
      else if (kind < 70)
         cmd.func = FUNC_W'($urandom_range(FUNC_CLEAR_ALL, FUNC_NEGATE_ALL));
      else if (kind < 94)
         cmd.func = FUNC_W'($urandom_range(FUNC_COUNT, FUNC_SUBSET));
      else
         cmd.func = FUNC_W'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST));
      cmd.bank = 1'($urandom_range(0, 1));
      if (where < 3) begin
         cmd.row_index    = ROW_IDX_W'($urandom_range(0, 3));
         cmd.column_index = COL_IDX_W'($urandom_range(0, 7));
      end else if (where < 8 && nrows > 0 && ncols > 0) begin
         cmd.row_index    = ROW_IDX_W'($urandom_range(0, nrows - 1));
         cmd.column_index = COL_IDX_W'($urandom_range(0, ncols - 1));
      end else begin
         cmd.row_index    = ROW_IDX_W'($urandom_range(0, MAXR - 1));
         cmd.column_index = COL_IDX_W'($urandom_range(0, 255));
      end
      return cmd;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // Sends one command word; called at a rising edge. Start stays high when the
   // next word follows at once, so it is never lowered and raised in one step.
   task automatic send_command(input req_word_type cmd, input int unsigned gap,
                               input logic typed, input rsp_word_type typed_result);
      rsp_word_type predicted;
      start    <= 1'b1;
      req_word <= cmd;
      do @(negedge clock); while (busy !== 1'b0);
      predicted = apply_matrix_command(cmd);
      pending_results.push_back(typed ? typed_result : predicted);
      @(posedge clock);
      if (gap > 0) begin
         start    <= 1'b0;
         req_word <= req_word_type'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // Holds off until every expected word is back and the block is idle.
   task automatic wait_until_drained();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      do @(negedge clock); while (busy !== 1'b0);
      @(posedge clock);
   endtask

   // Writes one register; csr_valid is left high for a following write.
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(negedge clock); while (csr_ready !== 1'b1);
      @(posedge clock);
      if (idx == CSR_ROWS_IN_USE)
         rows_reg = data[ROWS_REG_W-1:0];
      else
         cols_reg = data;
   endtask

   // Every result word is checked against the oldest expectation.
   always @(negedge clock) begin : result_check
      rsp_word_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result word with nothing expected (count %0d)",
                                      rsp_word.count));
         end else begin
            want = pending_results.pop_front();
            if (rsp_word.bit_value !== want.bit_value)
               report_mismatch($sformatf("bit_value %b, expected %b",
                                         rsp_word.bit_value, want.bit_value));
            if (rsp_word.count !== want.count)
               report_mismatch($sformatf("count %0d, expected %0d",
                                         rsp_word.count, want.count));
            if (rsp_word.subset_flag !== want.subset_flag)
               report_mismatch($sformatf("subset_flag %b, expected %b",
                                         rsp_word.subset_flag, want.subset_flag));
         end
      end
   end

   // Register settings of the first phases: reset sizes, smallest, above the
   // maximum, zero rows, zero columns, word boundary, just past it, one short.
   int unsigned phase_rows [FIXED_PHASES] = '{64, 1, 127, 0, 40, 64, 5, 64};
   int unsigned phase_cols [FIXED_PHASES] = '{256, 1, 511, 200, 0, 64, 65, 255};

   initial begin : stimulus
      int unsigned             gap;
      int unsigned             rows_value;
      int unsigned             cols_value;
      logic [CSR_DATA_W-1:0]   rows_data;
      for (int b = 0; b < 2; b++)
         for (int r = 0; r < MAXR; r++)
            bit_plane[b][r] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table; the first word waits out the clearing pass after reset.
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         gap = $urandom_range(0, 7);
         send_command(directed_steps[i].word, gap, directed_steps[i].typed,
                      directed_steps[i].result);
      end

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_until_drained();
         if (phase < FIXED_PHASES) begin
            rows_value = phase_rows[phase];
            cols_value = phase_cols[phase];
         end else begin
            rows_value = $urandom_range(1, 127);
            cols_value = $urandom_range(1, 511);
         end
         // The upper data bits of the rows register are don't-care.
         rows_data = {2'($urandom_range(0, 3)), ROWS_REG_W'(rows_value)};
         write_csr(CSR_ROWS_IN_USE, rows_data);
         write_csr(CSR_COLUMNS_IN_USE, CSR_DATA_W'(cols_value));
         csr_valid <= 1'b0;
         for (int item = 0; item < PHASE_ITEMS; item++) begin
            // Back-to-back stretches, random gaps elsewhere.
            gap = ((item % 64) < 12) ? 0 : $urandom_range(0, 7);
            send_command(random_command(), gap, 1'b0, '0);
            if ($urandom_range(0, 49) == 0)
               wait_until_drained();
         end
      end

      wait_until_drained();
      repeat (FINAL_QUIET_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("bit_matrix_engine_unit test passed");
      else
         $display("bit_matrix_engine_unit test failed");
      $finish;
   end

endmodule
